// File: hdl/assert_macros.svh
// shared assertion macros for the conversion block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))

`endif

// File: hdl/itoa_pkg.sv
package itoa_pkg;

  // width of the converted value
  localparam int VALUE_BITS = 64;

  // stream payload widths
  localparam int IN_FIELDS_W = 1 + VALUE_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  // decimal digits needed for the largest magnitude
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QADDR_W = $clog2(QDEPTH);

  // character codes
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;

  // conversion modes
  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  // one classified number
  typedef struct packed {
    logic                  mode;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } entry_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_DABBLE,
    B_SKIP,
    B_SIGN,
    B_EMIT
  } back_state_e;

  // add three to every bcd digit of five or more
  function automatic logic [DIG_W-1:0] bcd_adjust(input logic [DIG_W-1:0] bcd);
    logic [DIG_W-1:0] res;
    logic [3:0]       dig;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd[4*i +: 4];
      if (dig >= 4'd5) begin
        res[4*i +: 4] = dig + 4'd3;
      end
    end
    return res;
  endfunction

  // digit value to lowercase ascii
  function automatic logic [7:0] digit_char(input logic [3:0] dig);
    logic [7:0] res;
    if (dig < 4'd10) begin
      res = CHAR_ZERO + {4'b0000, dig};
    end else begin
      res = CHAR_A + {4'b0000, dig} - 8'd10;
    end
    return res;
  endfunction

endpackage

// File: hdl/itoa_front.sv
module itoa_front (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [itoa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output itoa_pkg::entry_t                  q_entry_o
);

  logic                            mode;
  logic [itoa_pkg::VALUE_BITS-1:0] value;
  logic                            neg;

  // unpack fields
  assign mode  = s_axis_tdata_i[0];
  assign value = s_axis_tdata_i[itoa_pkg::VALUE_BITS:1];

  // sign split: only decimal mode is signed, negation wraps for the most negative value
  assign neg = (mode == itoa_pkg::MODE_DEC) && value[itoa_pkg::VALUE_BITS-1];

  assign q_entry_o.mode = mode;
  assign q_entry_o.neg  = neg;
  assign q_entry_o.mag  = neg ? (~value + itoa_pkg::VALUE_BITS'(1)) : value;

  // accept whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

endmodule

// File: hdl/itoa_fifo.sv
`include "assert_macros.svh"

module itoa_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  itoa_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output itoa_pkg::entry_t entry_o
);

  itoa_pkg::entry_t              mem_q [itoa_pkg::QDEPTH];
  logic [itoa_pkg::QADDR_W:0]    wptr_q, wptr_d;
  logic [itoa_pkg::QADDR_W:0]    rptr_q, rptr_d;
  logic [itoa_pkg::QADDR_W:0]    fill;

  assign fill    = wptr_q - rptr_q;
  assign full_o  = (fill == (itoa_pkg::QADDR_W + 1)'(itoa_pkg::QDEPTH));
  assign valid_o = (fill != '0);
  assign entry_o = mem_q[rptr_q[itoa_pkg::QADDR_W-1:0]];

  // pointer update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q[itoa_pkg::QADDR_W-1:0]] <= entry_i;
    end
  end

  `ASSERT_AT(a_fill_bound, clk_i, rst_ni, fill <= (itoa_pkg::QADDR_W + 1)'(itoa_pkg::QDEPTH))

endmodule

// File: hdl/itoa_back.sv
`include "assert_macros.svh"

module itoa_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  itoa_pkg::entry_t                 q_entry_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [itoa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  itoa_pkg::back_state_e               state_q, state_d;
  logic [itoa_pkg::DIG_W-1:0]          bcd_q, bcd_d;
  logic [itoa_pkg::VALUE_BITS-1:0]     bin_q, bin_d;
  logic [itoa_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [itoa_pkg::NDIG_W-1:0]         ndig_q, ndig_d;
  logic                                neg_q, neg_d;
  logic [itoa_pkg::DIG_W-1:0]          bcd_adj;
  logic [3:0]                          top_dig;
  logic                                out_free;
  logic                                out_load;
  logic [7:0]                          out_char;
  logic                                out_last;
  logic                                ovalid_q;
  logic [7:0]                          ochar_q;
  logic                                olast_q;

  assign top_dig  = bcd_q[itoa_pkg::DIG_W-1 -: 4];
  assign bcd_adj  = itoa_pkg::bcd_adjust(bcd_q);
  assign out_free = !ovalid_q || m_axis_tready_i;

  // sequencer: load, shift-add-3 (decimal only), drop leading zeros, sign if negative, emit
  always_comb begin
    state_d  = state_q;
    bcd_d    = bcd_q;
    bin_d    = bin_q;
    cnt_d    = cnt_q;
    ndig_d   = ndig_q;
    neg_d    = neg_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    out_char = itoa_pkg::CHAR_MINUS;
    out_last = 1'b0;
    unique case (state_q)
      itoa_pkg::B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          neg_d   = q_entry_i.neg;
          ndig_d  = itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS);
          if (q_entry_i.mode == itoa_pkg::MODE_HEX) begin
            bcd_d   = {{(itoa_pkg::DIG_W - itoa_pkg::VALUE_BITS){1'b0}}, q_entry_i.mag};
            state_d = itoa_pkg::B_SKIP;
          end else begin
            bcd_d   = '0;
            bin_d   = q_entry_i.mag;
            cnt_d   = itoa_pkg::CNT_W'(itoa_pkg::VALUE_BITS - 1);
            state_d = itoa_pkg::B_DABBLE;
          end
        end
      end
      itoa_pkg::B_DABBLE: begin
        bcd_d = {bcd_adj[itoa_pkg::DIG_W-2:0], bin_q[itoa_pkg::VALUE_BITS-1]};
        bin_d = {bin_q[itoa_pkg::VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = itoa_pkg::B_SKIP;
        end
      end
      itoa_pkg::B_SKIP: begin
        if (top_dig == 4'd0 && ndig_q != itoa_pkg::NDIG_W'(1)) begin
          bcd_d  = {bcd_q[itoa_pkg::DIG_W-5:0], 4'b0000};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = neg_q ? itoa_pkg::B_SIGN : itoa_pkg::B_EMIT;
        end
      end
      itoa_pkg::B_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_char = itoa_pkg::CHAR_MINUS;
          state_d  = itoa_pkg::B_EMIT;
        end
      end
      itoa_pkg::B_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_char = itoa_pkg::digit_char(top_dig);
          out_last = (ndig_q == itoa_pkg::NDIG_W'(1));
          bcd_d    = {bcd_q[itoa_pkg::DIG_W-5:0], 4'b0000};
          ndig_d   = ndig_q - 1'b1;
          if (ndig_q == itoa_pkg::NDIG_W'(1)) begin
            state_d = itoa_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_d = itoa_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    bin_q  <= bin_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ochar_q <= out_char;
      olast_q <= out_last;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = ochar_q;
  assign m_axis_tlast_o  = olast_q;

  `ASSERT_NEVER(a_emit_has_digit, clk_i, rst_ni, state_q == itoa_pkg::B_EMIT && ndig_q == '0)
  `ASSERT_AT(a_sign_then_digit, clk_i, rst_ni, (state_q == itoa_pkg::B_SIGN && out_load) |=> (state_q == itoa_pkg::B_EMIT && neg_q))

endmodule

// File: hdl/integer_to_ascii_digits.sv
// channel   dir  tdata                                tlast
// s_axis    in   [0] mode, [64:1] value, [71:65] zero  -
// m_axis    out  [7:0] char_code                      last
//
// hex: load the magnitude, then drop leading zeros and emit the digits
// decimal: load, shift-add-3 over the value bits, drop leading zeros, a sign if negative, emit
// the shift-add-3 loop in the back end takes one value bit per cycle
// a sink stall holds the back end; a two-entry queue keeps the front accepting
// reset clears the queue pointers, the sequencer and the output valid
module integer_to_ascii_digits (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [itoa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // mode, value, zero pad
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [itoa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,  // char_code
  output logic                             m_axis_tlast_o
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  itoa_pkg::entry_t q_in;
  itoa_pkg::entry_t q_out;

  // classify incoming numbers
  itoa_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  // decoupling queue
  itoa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  // convert and emit characters
  itoa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: tb/itoa_digit_checker.sv
// watches both stream channels, predicts the characters of every accepted
// number and compares each output transaction with the oldest prediction
module itoa_digit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [itoa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // mode, value, zero pad
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [itoa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,  // char_code
  input  logic                             m_axis_tlast_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               chars_o
);

  localparam logic [7:0] GLYPH_ZERO  = "0";
  localparam logic [7:0] GLYPH_A     = "a";
  localparam logic [7:0] GLYPH_MINUS = "-";
  localparam int         REPORT_MAX  = 10;

  // one predicted character
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_exp_t;

  char_exp_t expected_chars[$];

  int errors;
  int chars_seen;
  int pending;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign chars_o   = chars_seen;

  initial begin
    errors     = 0;
    chars_seen = 0;
    pending    = 0;
  end

  function automatic logic [7:0] glyph_of(input logic [3:0] dig);
    if (dig < 4'd10) begin
      return GLYPH_ZERO + {4'b0000, dig};
    end
    return GLYPH_A + {4'b0000, dig} - 8'd10;
  endfunction

  // queue the characters that one number must produce
  function automatic void predict_digits(input logic mode,
                                         input logic [itoa_pkg::VALUE_BITS-1:0] value);
    logic [itoa_pkg::VALUE_BITS-1:0] mag;
    logic [itoa_pkg::VALUE_BITS-1:0] radix;
    logic [7:0]                      rev[$];
    char_exp_t                       item;
    mag   = value;
    radix = (mode == itoa_pkg::MODE_HEX) ? itoa_pkg::VALUE_BITS'(16)
                                         : itoa_pkg::VALUE_BITS'(10);
    // negative decimal: sign first, magnitude wraps for the most negative value
    if (mode == itoa_pkg::MODE_DEC && value[itoa_pkg::VALUE_BITS-1]) begin
      item.code = GLYPH_MINUS;
      item.last = 1'b0;
      expected_chars.push_back(item);
      mag = -value;
    end
    if (mag == '0) begin
      item.code = GLYPH_ZERO;
      item.last = 1'b1;
      expected_chars.push_back(item);
    end else begin
      // digits come out least significant first
      while (mag != '0) begin
        rev.push_back(glyph_of(4'(mag % radix)));
        mag = mag / radix;
      end
      for (int k = rev.size() - 1; k >= 0; k--) begin
        item.code = rev[k];
        item.last = (k == 0);
        expected_chars.push_back(item);
      end
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    char_exp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_digits(s_axis_tdata_i[0], s_axis_tdata_i[itoa_pkg::VALUE_BITS:1]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("%0t: unexpected character 0x%02h last %0b", $realtime,
                     m_axis_tdata_i, m_axis_tlast_i);
          end
        end else begin
          want = expected_chars.pop_front();
          if (want.code !== m_axis_tdata_i || want.last !== m_axis_tlast_i) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("%0t: character mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                       $realtime, want.code, want.last, m_axis_tdata_i, m_axis_tlast_i);
            end
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// File: tb/tb_integer_to_ascii_digits.sv
// stimulus and verdict for the number to ascii conversion block
module tb_integer_to_ascii_digits;

  localparam int RANDOM_NUMBERS = 200;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int TAIL_CYCLES    = 200;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [itoa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [itoa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  int errors;
  int pending;
  int chars_checked;

  logic idling_en;
  int   stall_left;
  int   dec_sent;
  int   hex_sent;

  integer_to_ascii_digits dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  itoa_digit_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .errors_o        (errors),
    .pending_o       (pending),
    .chars_o         (chars_checked)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // sink side: random stall bursts while idling is enabled
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_en && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // offer one number and hold it until the transaction completes
  task automatic send_number(input logic mode,
                             input logic [itoa_pkg::VALUE_BITS-1:0] value);
    logic [itoa_pkg::IN_TDATA_W-1:0] word;
    int                              gap;
    if (idling_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word                         = '0;
    word[0]                      = mode;
    word[itoa_pkg::VALUE_BITS:1] = value;
    s_axis_tvalid               <= 1'b1;
    s_axis_tdata                <= word;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    @(negedge clk_i);
    if (mode == itoa_pkg::MODE_HEX) begin
      hex_sent++;
    end else begin
      dec_sent++;
    end
  endtask

  // hold off the sender until every predicted character has come out
  task automatic wait_drained();
    int cycles;
    cycles = 0;
    s_axis_tvalid <= 1'b0;
    while (pending != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk_i);
      cycles++;
    end
  endtask

  // random value with a shape picked to hit short, long and boundary numbers
  function automatic logic [itoa_pkg::VALUE_BITS-1:0] shaped_value();
    logic [itoa_pkg::VALUE_BITS-1:0] raw;
    logic [itoa_pkg::VALUE_BITS-1:0] pow;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return raw;
      1: return itoa_pkg::VALUE_BITS'($urandom_range(0, 1000));
      2: return raw >> $urandom_range(0, itoa_pkg::VALUE_BITS - 1);
      3: return -(raw >> $urandom_range(0, itoa_pkg::VALUE_BITS - 1));
      4: begin
        pow = 64'd1;
        repeat ($urandom_range(0, 19)) pow = pow * 64'd10;
        return pow + itoa_pkg::VALUE_BITS'($urandom_range(0, 2)) - 64'd1;
      end
      default: return (itoa_pkg::VALUE_BITS'(1) << $urandom_range(0, itoa_pkg::VALUE_BITS - 1))
                      - itoa_pkg::VALUE_BITS'($urandom_range(0, 1));
    endcase
  endfunction

  initial begin
    logic [itoa_pkg::VALUE_BITS-1:0] min_neg;
    logic [itoa_pkg::VALUE_BITS-1:0] all_ones;
    int                              cycles;
    min_neg       = {1'b1, {(itoa_pkg::VALUE_BITS - 1){1'b0}}};
    all_ones      = '1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    idling_en     = 1'b0;
    stall_left    = 0;
    dec_sent      = 0;
    hex_sent      = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero, sign handling, most negative, extremes of both modes
    send_number(itoa_pkg::MODE_DEC, '0);
    send_number(itoa_pkg::MODE_HEX, '0);
    send_number(itoa_pkg::MODE_DEC, 64'd1);
    send_number(itoa_pkg::MODE_HEX, 64'd1);
    send_number(itoa_pkg::MODE_DEC, all_ones);
    send_number(itoa_pkg::MODE_HEX, all_ones);
    send_number(itoa_pkg::MODE_DEC, min_neg);
    send_number(itoa_pkg::MODE_HEX, min_neg);
    send_number(itoa_pkg::MODE_DEC, min_neg - 64'd1);
    send_number(itoa_pkg::MODE_DEC, min_neg + 64'd1);
    send_number(itoa_pkg::MODE_DEC, 64'd9);
    send_number(itoa_pkg::MODE_DEC, 64'd10);
    send_number(itoa_pkg::MODE_DEC, -64'd10);
    send_number(itoa_pkg::MODE_HEX, 64'd15);
    send_number(itoa_pkg::MODE_HEX, 64'd16);
    send_number(itoa_pkg::MODE_DEC, 64'd1000000000000000000);
    send_number(itoa_pkg::MODE_DEC, 64'd999999999999999999);
    send_number(itoa_pkg::MODE_HEX, 64'hfedcba9876543210);
    send_number(itoa_pkg::MODE_HEX, 64'h0123456789abcdef);
    send_number(itoa_pkg::MODE_DEC, 64'h5555555555555555);
    send_number(itoa_pkg::MODE_DEC, 64'haaaaaaaaaaaaaaaa);
    wait_drained();

    // random: idling, none, idling with a drain stop, none at the end
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      idling_en = (i < RANDOM_NUMBERS / 4) ||
                  (i >= RANDOM_NUMBERS / 2 && i < (3 * RANDOM_NUMBERS) / 4);
      if (i == (5 * RANDOM_NUMBERS) / 8) begin
        wait_drained();
      end
      send_number(1'($urandom_range(0, 1)), shaped_value());
    end
    s_axis_tvalid <= 1'b0;
    idling_en      = 1'b0;

    // drain, then watch for stray characters
    cycles = 0;
    while (pending != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("converted %0d numbers: %0d signed decimal, %0d hex",
             dec_sent + hex_sent, dec_sent, hex_sent);
    $display("checked %0d characters, %0d mismatches, %0d still expected",
             chars_checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/itoa_pkg.sv
hdl/itoa_front.sv
hdl/itoa_fifo.sv
hdl/itoa_back.sv
hdl/integer_to_ascii_digits.sv
tb/itoa_digit_checker.sv
tb/tb_integer_to_ascii_digits.sv
